/* rtl/assert_macros.svh */
// Assertion macros shared by the RGBE converter RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rgbe_pkg.sv */
// Package for the RGBE converter: payload structs, operation codes, helpers.
// No dependencies.
package rgbe_pkg;

    typedef enum logic {
        FUNC_DECODE = 1'b0,
        FUNC_ENCODE = 1'b1
    } func_t;

    typedef struct packed {
        logic        func;
        logic [31:0] rgbe_in;
        logic [31:0] red_in;
        logic [31:0] green_in;
        logic [31:0] blue_in;
    } req_t;

    typedef struct packed {
        logic [31:0] rgbe_out;
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
        logic        out_of_range;
    } rsp_t;

    localparam logic [31:0] TINY_BITS = 32'h0A4F_B11F;
    localparam logic [7:0]  EXP_SAT   = 8'd254;

    // One mantissa byte to IEEE single, given a nonzero shared exponent byte.
    function automatic logic [31:0] decode_chan(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  p;
        logic [9:0]  biased;
        logic [30:0] sh;
        p = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (m[i]) p = i[2:0];
        end
        biased = {7'd0, p} + {2'd0, e} - 10'd9;
        if (m == 8'd0) begin
            decode_chan = 32'd0;
        end else if (biased[9] || biased == 10'd0) begin
            // subnormal: m << (e + 13), e <= 9 here
            sh = {23'd0, m} << (e[4:0] + 5'd13);
            decode_chan = {9'd0, sh[22:0]};
        end else begin
            sh = {23'd0, m} << (5'd23 - {2'd0, p});
            decode_chan = {1'b0, biased[7:0], sh[22:0]};
        end
    endfunction

    // Truncated mantissa byte for one clamped component against max exponent.
    function automatic logic [7:0] encode_chan(input logic [31:0] bits, input logic [7:0] mexp);
        logic [7:0]  b;
        logic [7:0]  eb;
        logic [23:0] s;
        logic [8:0]  k;
        logic [23:0] sh;
        b  = bits[30:23];
        eb = (b != 8'd0) ? b : 8'd1;
        s  = {(b != 8'd0), bits[22:0]};
        k  = {1'b0, mexp} - {1'b0, eb} + 9'd16;
        sh = s >> k[4:0];
        if (eb > mexp || k >= 9'd32) begin
            encode_chan = 8'd0;
        end else begin
            encode_chan = sh[7:0];
        end
    endfunction

endpackage

/* rtl/rgbe_core.sv */
// Combinational RGBE decode/encode datapath for one request.
// Depends on rgbe_pkg.
module rgbe_core
    import rgbe_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);
    logic [31:0] c0, c1, c2, mx01, mx;
    logic        bad;
    logic [7:0]  e, mexp;
    logic [7:0]  mexp2;

    // clamp negatives, pick the largest bit pattern
    assign c0   = req.red_in[31]   ? 32'd0 : req.red_in;
    assign c1   = req.green_in[31] ? 32'd0 : req.green_in;
    assign c2   = req.blue_in[31]  ? 32'd0 : req.blue_in;
    assign mx01 = (c1 > c0) ? c1 : c0;
    assign mx   = (c2 > mx01) ? c2 : mx01;
    assign bad  = (&req.red_in[30:23]) | (&req.green_in[30:23]) | (&req.blue_in[30:23]);
    assign mexp = mx[30:23];
    assign mexp2 = mexp + 8'd2;
    assign e    = req.rgbe_in[31:24];

    always_comb begin
        rsp = '0;
        if (req.func == FUNC_DECODE) begin
            if (e != 8'd0) begin
                rsp.red_out   = decode_chan(req.rgbe_in[7:0], e);
                rsp.green_out = decode_chan(req.rgbe_in[15:8], e);
                rsp.blue_out  = decode_chan(req.rgbe_in[23:16], e);
            end
        end else if (bad || (mx >= TINY_BITS && mexp >= EXP_SAT)) begin
            rsp.rgbe_out     = 32'hFFFF_FFFF;
            rsp.out_of_range = 1'b1;
        end else if (mx >= TINY_BITS) begin
            rsp.rgbe_out = {mexp2, encode_chan(c2, mexp), encode_chan(c1, mexp),
                            encode_chan(c0, mexp)};
        end
    end
endmodule

/* rtl/rgbe_float_converter.sv */
// Top level of the RGBE converter: input register, datapath, result register.
// Depends on rgbe_pkg, rgbe_core and assert_macros.svh.
//
//  channel | ports             | payload
//  input   | s_valid / s_ready | s_data (req_t)
//  result  | m_valid / m_ready | m_data (rsp_t)
//
// One request per clock unless m_ready stalls the result register.
// The whole conversion is one combinational pass between the two registers.
// aresetn clears both valid flags synchronously.
// A stalled result holds the result stage; the input stage holds its request
// until the result stage frees, so nothing is lost under back-pressure.
`include "assert_macros.svh"
module rgbe_float_converter
    import rgbe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);
    logic in_vld_reg, out_vld_reg;
    req_t in_reg;
    rsp_t out_reg, core_rsp;
    logic adv;

    rgbe_core u_core (.req(in_reg), .rsp(core_rsp));

    // stage moves when result slot is empty or being taken
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) in_vld_reg <= s_valid;
            if (adv) out_vld_reg <= in_vld_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_reg <= s_data;
        if (adv && in_vld_reg) out_reg <= core_rsp;
    end

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `ASSERT_IMPL(a_dec_flag, aclk, aresetn, m_valid && m_data.rgbe_out == 32'd0 && m_data.red_out != 32'd0, !m_data.out_of_range)
    `ASSERT_NEXT(a_flow, aclk, aresetn, in_vld_reg && adv, out_vld_reg)
    `ASSERT_IMPL(a_flag_sat, aclk, aresetn, m_valid && m_data.out_of_range, m_data.rgbe_out == 32'hFFFF_FFFF)
endmodule
